### hdl/ars_pkg.sv
// Shared types and constants of the activity run segmenter.
package ars_pkg;

	localparam int unsigned CntW = 16;
	localparam int unsigned LenW = 17;
	localparam int unsigned PosW = 32;
	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REC = 2'd1,
		MODE_AWAIT = 2'd2
	} mode_t;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [CfgIdxW-1:0] REG_MIN_PRESENCE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_PRESENCE = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_END_GAP = 2'd2;

	localparam logic [CntW-1:0] MIN_PRESENCE_RST = 16'd8;
	localparam logic [CntW-1:0] MAX_PRESENCE_RST = 16'd64;
	localparam logic [CntW-1:0] END_GAP_RST = 16'd5;

	localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};
	localparam logic [LenW-1:0] LEN_MAX = {LenW{1'b1}};

	typedef struct packed {
		logic [CntW-1:0] min_presence;
		logic [CntW-1:0] max_presence;
		logic [CntW-1:0] end_gap;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic [CntW-1:0] presence_count;
		logic [CntW-1:0] empty_run;
		logic [CntW-1:0] release_run;
		logic [PosW-1:0] frame_position;
		logic [PosW-1:0] start_position;
		logic [LenW-1:0] recorded_frames;
	} seg_state_t;

	typedef struct packed {
		logic [PosW-1:0] segment_start;
		logic [LenW-1:0] segment_frames;
		logic [CntW-1:0] presence_frames;
		logic limit_reached;
	} seg_result_t;

endpackage

### hdl/activity_run_segmenter_top.sv
// Top level of the activity run segmenter: state, configuration and result register.
//
// Takes one item per transfer: a frame with its presence flag, or a flush at the end of
// the stream. It tracks idle, recording and await-release modes, and for each segment
// that holds enough presence frames it returns one result: the frame position of the
// first presence frame, the length with trailing empty frames trimmed, the presence count
// and whether the maximum count ended it. An item is taken in every cycle when the result
// register is empty or its contents are being transferred out; the only work is the
// next-state logic between the state registers and the result register, so a result
// appears in the cycle after its input transfer and the sustained rate is one item per
// cycle. Configuration writes are registered and apply from the next item on.
module activity_run_segmenter_top import ars_pkg::*; (
	input logic clk,
	input logic arst_n,
	// configuration
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CntW-1:0] cfg_data,
	// input channel
	input logic in_valid,
	output logic in_ready,
	input logic operation,
	input logic has_presence,
	// result channel
	output logic out_valid,
	input logic out_ready,
	output logic [PosW-1:0] segment_start,
	output logic [LenW-1:0] segment_frames,
	output logic [CntW-1:0] presence_frames,
	output logic limit_reached
);

	cfg_t cfg_q;
	seg_state_t st_q;
	seg_state_t st_nxt;
	logic res_valid;
	seg_result_t res;
	seg_result_t res_q;
	logic out_valid_q;
	logic in_xfer;

	// Accept whenever the result register is free or is being drained this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer = in_valid && in_ready;

	// Hold the three thresholds; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_presence <= MIN_PRESENCE_RST;
			cfg_q.max_presence <= MAX_PRESENCE_RST;
			cfg_q.end_gap <= END_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_PRESENCE: cfg_q.min_presence <= cfg_data;
				REG_MAX_PRESENCE: cfg_q.max_presence <= cfg_data;
				REG_END_GAP: cfg_q.end_gap <= cfg_data;
				default: ;
			endcase
		end
	end

	ars_step u_step (
		.cfg(cfg_q),
		.st(st_q),
		.operation(operation),
		.has_presence(has_presence),
		.nxt(st_nxt),
		.res_valid(res_valid),
		.res(res)
	);

	// Advance the segment state only on an input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_IDLE, default: '0};
		end else if (in_xfer) begin
			st_q <= st_nxt;
		end
	end

	// Result register: load on an input transfer, clear once transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign segment_start = res_q.segment_start;
	assign segment_frames = res_q.segment_frames;
	assign presence_frames = res_q.presence_frames;
	assign limit_reached = res_q.limit_reached;

	// A new result only ever follows an input transfer.
	a_result_needs_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_xfer))
		else $error("result appeared without an input transfer");

	// Outside recording the segment counters sit at zero.
	a_idle_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode != MODE_REC) |-> (st_q.presence_count == '0 && st_q.empty_run == '0
			&& st_q.recorded_frames == '0))
		else $error("segment counters not clear outside recording");

	// While recording, at least one frame is counted and the empty run fits inside it.
	a_rec_length_covers_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_REC) |-> (st_q.recorded_frames != '0
			&& st_q.recorded_frames >= {1'b0, st_q.empty_run}))
		else $error("recorded length inconsistent with empty run");

	// The release counter only runs while awaiting release.
	a_release_only_await: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode != MODE_AWAIT) |-> (st_q.release_run == '0))
		else $error("release run counting outside await-release");

endmodule

### hdl/ars_step.sv
// Next-state and result logic for one transferred item.
module ars_step import ars_pkg::*; (
	input cfg_t cfg,
	input seg_state_t st,
	input logic operation,
	input logic has_presence,
	output seg_state_t nxt,
	output logic res_valid,
	output seg_result_t res
);

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [LenW-1:0] trim(input logic [LenW-1:0] rec,
		input logic [CntW-1:0] er);
		logic [LenW-1:0] er_w;
		er_w = {1'b0, er};
		return (rec >= er_w) ? rec - er_w : '0;
	endfunction

	logic end_seg;
	logic by_limit;
	logic [LenW-1:0] len;
	logic [CntW-1:0] pc_w;
	logic [CntW-1:0] er_w;
	logic [CntW-1:0] rr_w;
	logic [LenW-1:0] rec_w;
	logic [CntW-1:0] pc_b;
	logic [LenW-1:0] rec_b;

	always_comb begin
		nxt = st;
		end_seg = 1'b0;
		by_limit = 1'b0;
		len = '0;
		pc_w = st.presence_count;
		er_w = st.empty_run;
		rr_w = sat_inc(st.release_run);
		pc_b = st.presence_count;
		rec_b = st.recorded_frames;
		rec_w = st.recorded_frames;
		if (operation == OP_FLUSH) begin
			if (st.mode != MODE_REC) begin
				nxt.mode = MODE_IDLE;
				nxt.release_run = '0;
			end else begin
				end_seg = 1'b1;
				len = trim(st.recorded_frames, st.empty_run);
			end
		end else begin
			nxt.frame_position = st.frame_position + 1'b1;
			if (st.mode == MODE_AWAIT) begin
				if (has_presence) begin
					nxt.release_run = '0;
				end else if (rr_w >= cfg.end_gap) begin
					nxt.mode = MODE_IDLE;
					nxt.release_run = '0;
				end else begin
					nxt.release_run = rr_w;
				end
			end else if (st.mode == MODE_REC || has_presence) begin
				// open a segment on the first presence frame
				if (st.mode != MODE_REC) begin
					nxt.mode = MODE_REC;
					nxt.start_position = st.frame_position;
					pc_b = '0;
					rec_b = '0;
					er_w = '0;
				end
				rec_w = (rec_b == LEN_MAX) ? rec_b : rec_b + 1'b1;
				nxt.recorded_frames = rec_w;
				if (has_presence) begin
					pc_w = sat_inc(pc_b);
					er_w = '0;
					nxt.presence_count = pc_w;
					nxt.empty_run = '0;
					if (pc_w >= cfg.max_presence) begin
						end_seg = 1'b1;
						by_limit = 1'b1;
						len = rec_w;
					end
				end else begin
					pc_w = pc_b;
					er_w = sat_inc(er_w);
					nxt.presence_count = pc_b;
					nxt.empty_run = er_w;
					if (er_w >= cfg.end_gap) begin
						end_seg = 1'b1;
						len = trim(rec_w, er_w);
					end
				end
			end
		end
		if (end_seg) begin
			nxt.mode = by_limit ? MODE_AWAIT : MODE_IDLE;
			nxt.release_run = '0;
			nxt.presence_count = '0;
			nxt.empty_run = '0;
			nxt.recorded_frames = '0;
		end
	end

	assign res_valid = end_seg && (pc_w >= cfg.min_presence);
	assign res.segment_start = st.mode == MODE_REC ? st.start_position : st.frame_position;
	assign res.segment_frames = len;
	assign res.presence_frames = pc_w;
	assign res.limit_reached = by_limit;

endmodule
